[hdl/bitmap_block_allocator_macros.svh]
// Assertion macros shared by the checker of the bitmap block allocator.
// Depends on nothing; the including file supplies clock, reset and expressions.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("bitmap block allocator check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define BBA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bitmap block allocator check failed");

`endif

[hdl/bba_pkg.sv]
// Package of the bitmap block allocator: field widths, request and status codes,
// and the command and status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned BLK_W    = 12;
  localparam int unsigned WIDX_W   = 7;
  localparam int unsigned WVAL_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TB_W     = 13;

  // Reset value of the volume size register.
  localparam logic [TB_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_BLOCKS_DEF    = 4096;
  localparam int unsigned MAP_WORD_BITS_DEF = 32;

  // Request kinds.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_LOAD  = 2'd3
  } mode_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // write one zero word of the clearing pass
    logic start;     // capture the accepted item
    logic scan;      // advance the bitmap walk by one word
    logic load_out;  // move the finished result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // the clearing pass writes its last word
    logic need_scan;  // the item on the input needs a walk over the bitmap
    logic hit;        // the word under evaluation settles the item
    logic exhausted;  // the walk ran past the last word in range
  } dp_stat_t;

endpackage

[hdl/bba_ctrl.sv]
// Controller of the bitmap block allocator: one-hot state machine and output valid.
// Depends on bba_pkg for the command and status bundles.
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  bba_pkg::dp_stat_t   stat_i,
  output bba_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  // Items are taken only when nothing is in progress.
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  // The output register can take a result when empty or being emptied now.
  assign slot_free  = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.start = accept;
        if (accept) begin
          state_d = stat_i.need_scan ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit || stat_i.exhausted) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        cmd_o.load_out = slot_free;
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Output valid is set by a new result and dropped once the item is taken.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/bba_datapath.sv]
// Datapath of the bitmap block allocator: bitmap memory, word walk, bit search
// and result registers. Depends on bba_pkg; driven by bba_ctrl.
`timescale 1ns / 1ps

module bba_datapath #(
  parameter int unsigned MAX_BLOCKS    = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bba_pkg::TB_W-1:0]      cfg_wdata_i,
  input  logic [bba_pkg::MODE_W-1:0]    mode_i,
  input  logic [bba_pkg::BLK_W-1:0]     block_number_i,
  input  logic [bba_pkg::WIDX_W-1:0]    word_index_i,
  input  logic [bba_pkg::WVAL_W-1:0]    word_value_i,
  input  bba_pkg::ctrl_cmd_t            cmd_i,
  output bba_pkg::dp_stat_t             stat_o,
  output logic [bba_pkg::STATUS_W-1:0]  status_o,
  output logic [bba_pkg::BLK_W-1:0]     allocated_block_o,
  output logic                          block_free_o
);

  localparam int unsigned MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned OFF_W     = $clog2(MAP_WORD_BITS);
  localparam int unsigned LIM_BITS  = $clog2(MAX_BLOCKS + 2 * MAP_WORD_BITS + 1);
  localparam int unsigned BASE_W    = (LIM_BITS > bba_pkg::TB_W) ? LIM_BITS : bba_pkg::TB_W;

  localparam logic [BASE_W-1:0] MAXB  = BASE_W'(MAX_BLOCKS);
  localparam logic [BASE_W-1:0] WSTEP = BASE_W'(MAP_WORD_BITS);

  // Bitmap store: a set bit marks a free block.
  logic [MAP_WORD_BITS-1:0] free_map_q [MAP_WORDS];

  logic [bba_pkg::TB_W-1:0]  total_q;
  logic [BASE_W-1:0]         limit;
  logic [BASE_W-1:0]         blk_in;
  bba_pkg::mode_e            in_mode;
  logic                      load_in_range;
  logic                      need_scan;
  bba_pkg::status_e          start_status;

  bba_pkg::mode_e            op_q;
  logic [bba_pkg::BLK_W-1:0] blk_q;
  logic [BASE_W-1:0]         scan_lim_q;
  logic [AW-1:0]             rd_addr_q;
  logic [BASE_W-1:0]         rd_base_q;
  logic                      ev_live_q;
  logic                      ev_in_q;
  logic [BASE_W-1:0]         ev_base_q;
  logic [AW-1:0]             ev_addr_q;
  logic [MAP_WORD_BITS-1:0]  rdata_q;
  logic [AW-1:0]             clr_q;

  bba_pkg::status_e          res_status_q;
  logic [bba_pkg::BLK_W-1:0] res_block_q;
  logic                      res_free_q;
  bba_pkg::status_e          out_status_q;
  logic [bba_pkg::BLK_W-1:0] out_block_q;
  logic                      out_free_q;

  logic [BASE_W-1:0]         rem;
  logic [BASE_W-1:0]         blk_ext;
  logic [MAP_WORD_BITS-1:0]  lim_mask;
  logic [MAP_WORD_BITS-1:0]  masked;
  logic [MAP_WORD_BITS-1:0]  low_bit;
  logic [OFF_W-1:0]          first_idx;
  logic [OFF_W-1:0]          bit_off;
  logic [MAP_WORD_BITS-1:0]  off_bit;
  logic                      locate_hit;
  logic                      hit;
  logic                      exhausted;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [MAP_WORD_BITS-1:0]  wr_data;

  // Effective block limit: the smaller of the register and the map size.
  always_comb begin
    limit = BASE_W'(total_q);
    if (limit > MAXB) begin
      limit = MAXB;
    end
  end

  // Decode of the item on the input.
  assign in_mode       = bba_pkg::mode_e'(mode_i);
  assign blk_in        = BASE_W'(block_number_i);
  assign load_in_range = BASE_W'(word_index_i) < BASE_W'(MAP_WORDS);

  always_comb begin
    case (in_mode)
      bba_pkg::MODE_ALLOC: need_scan = 1'b1;
      bba_pkg::MODE_FREE:  need_scan = (blk_in >= BASE_W'(2)) && (blk_in < MAXB);
      bba_pkg::MODE_QUERY: need_scan = (blk_in != '0) && (blk_in < limit);
      default:             need_scan = 1'b0;
    endcase
  end

  // Result known at acceptance; a walk may overwrite it on a hit.
  always_comb begin
    start_status = bba_pkg::ST_OK;
    if (in_mode == bba_pkg::MODE_ALLOC) begin
      start_status = bba_pkg::ST_NOSPACE;
    end else if (in_mode == bba_pkg::MODE_FREE && blk_in < BASE_W'(2)) begin
      start_status = bba_pkg::ST_INVALID;
    end
  end

  // Blocks of the evaluated word inside 1 to scan_lim_q-1 (limit for an allocate, else MAX_BLOCKS).
  always_comb begin
    rem = scan_lim_q - ev_base_q;
    if (rem >= WSTEP) begin
      lim_mask = '1;
    end else begin
      lim_mask = ~({MAP_WORD_BITS{1'b1}} << rem[OFF_W-1:0]);
    end
    if (ev_base_q == '0) begin
      lim_mask[0] = 1'b0;
    end
  end

  assign masked  = rdata_q & lim_mask;
  assign low_bit = masked & (~masked + MAP_WORD_BITS'(1));

  // Lowest free position in the evaluated word.
  always_comb begin
    first_idx = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (masked[b]) begin
        first_idx = OFF_W'(b);
      end
    end
  end

  // Position of a free or query block relative to the evaluated word.
  assign blk_ext    = BASE_W'(blk_q);
  assign bit_off    = OFF_W'(blk_ext - ev_base_q);
  assign off_bit    = MAP_WORD_BITS'(1) << bit_off;
  assign locate_hit = blk_ext < (ev_base_q + WSTEP);

  assign hit       = ev_live_q && ev_in_q &&
                     ((op_q == bba_pkg::MODE_ALLOC) ? (|masked) : locate_hit);
  assign exhausted = ev_live_q && !ev_in_q;

  assign stat_o.clr_last  = (clr_q == AW'(MAP_WORDS - 1));
  assign stat_o.need_scan = need_scan;
  assign stat_o.hit       = hit;
  assign stat_o.exhausted = exhausted;

  // Single write port: clearing pass, word load, or the update after a hit.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_data = '0;
    if (cmd_i.clear) begin
      wr_en = 1'b1;
    end else if (cmd_i.start && in_mode == bba_pkg::MODE_LOAD && load_in_range) begin
      wr_en   = 1'b1;
      wr_addr = AW'(word_index_i);
      wr_data = MAP_WORD_BITS'(word_value_i);
    end else if (cmd_i.scan && hit && op_q != bba_pkg::MODE_QUERY) begin
      wr_en   = 1'b1;
      wr_addr = ev_addr_q;
      wr_data = (op_q == bba_pkg::MODE_ALLOC) ? (rdata_q & ~low_bit) : (rdata_q | off_bit);
    end
  end

  // Bitmap memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      free_map_q[wr_addr] <= wr_data;
    end
    rdata_q <= free_map_q[rd_addr_q];
  end

  // Control registers: volume size, clearing counter, evaluation flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= bba_pkg::TOTAL_BLOCKS_RST;
      clr_q     <= '0;
      ev_live_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.start) begin
        ev_live_q <= 1'b0;
      end else if (cmd_i.scan) begin
        ev_live_q <= 1'b1;
      end
    end
  end

  // Walk over the bitmap: one read issued and one word evaluated per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q       <= in_mode;
      blk_q      <= block_number_i;
      rd_addr_q  <= '0;
      rd_base_q  <= '0;
      scan_lim_q <= (in_mode == bba_pkg::MODE_ALLOC) ? limit : MAXB;
    end else if (cmd_i.scan) begin
      ev_in_q   <= rd_base_q < scan_lim_q;
      ev_base_q <= rd_base_q;
      ev_addr_q <= rd_addr_q;
      rd_addr_q <= rd_addr_q + AW'(1);
      rd_base_q <= rd_base_q + WSTEP;
    end
  end

  // Result of the item in progress and the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      res_status_q <= start_status;
      res_block_q  <= '0;
      res_free_q   <= 1'b0;
    end else if (cmd_i.scan && hit) begin
      if (op_q == bba_pkg::MODE_ALLOC) begin
        res_status_q <= bba_pkg::ST_OK;
        res_block_q  <= bba_pkg::BLK_W'(ev_base_q + BASE_W'(first_idx));
      end
      if (op_q == bba_pkg::MODE_QUERY) begin
        res_free_q <= rdata_q[bit_off];
      end
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_block_q  <= res_block_q;
      out_free_q   <= res_free_q;
    end
  end

  assign status_o          = out_status_q;
  assign allocated_block_o = out_block_q;
  assign block_free_o      = out_free_q;

endmodule

[hdl/bitmap_block_allocator.sv]
// Top level of the bitmap block allocator: controller and datapath joined.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
`timescale 1ns / 1ps

// First-fit block allocator over a free-block bitmap held in a single-port-write
// memory of MAX_BLOCKS/MAP_WORD_BITS words (128 words by default). After reset a
// clearing pass writes one word per cycle, and the block stalls its input until
// the pass has written its last word; total_blocks may be written meanwhile.
// Items are handled one at a time, and the time per item is set by the bitmap
// walk, which reads one word per cycle. An allocate walks up to and including
// the word holding the lowest free block, or over every word below the limit
// when no block is free. A free or query of block b walks to its word; a load,
// or a request settled by its block number alone, needs no walk.
// A new item is accepted the cycle after the previous result reaches the output
// register, even while that result is still stalled.

module bitmap_block_allocator #(
  parameter int unsigned MAX_BLOCKS    = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bba_pkg::TB_W-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bba_pkg::MODE_W-1:0]    mode_i,
  input  logic [bba_pkg::BLK_W-1:0]     block_number_i,
  input  logic [bba_pkg::WIDX_W-1:0]    word_index_i,
  input  logic [bba_pkg::WVAL_W-1:0]    word_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bba_pkg::STATUS_W-1:0]  status_o,
  output logic [bba_pkg::BLK_W-1:0]     allocated_block_o,
  output logic                          block_free_o
);

  bba_pkg::ctrl_cmd_t cmd;
  bba_pkg::dp_stat_t  stat;

  // Sequencing of clearing, acceptance, walk and result hand-over.
  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Bitmap memory, search logic and result registers.
  bba_datapath #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mode_i            (mode_i),
    .block_number_i    (block_number_i),
    .word_index_i      (word_index_i),
    .word_value_i      (word_value_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .status_o          (status_o),
    .allocated_block_o (allocated_block_o),
    .block_free_o      (block_free_o)
  );

endmodule

[hdl/bba_checker.sv]
// Port-level checks of the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and the assertion macros in bitmap_block_allocator_macros.svh.
`timescale 1ns / 1ps
`include "bitmap_block_allocator_macros.svh"

module bba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bba_pkg::STATUS_W-1:0]  status_o,
  input logic [bba_pkg::BLK_W-1:0]     allocated_block_o,
  input logic                          block_free_o
);

  // A stalled result stays offered.
  `BBA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Only the three defined status codes are ever reported.
  `BBA_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid_o, (status_o == bba_pkg::ST_OK) || (status_o == bba_pkg::ST_NOSPACE) || (status_o == bba_pkg::ST_INVALID))

  // A claimed block or a free answer comes only with an ok status.
  `BBA_ASSERT_IMP(a_payload_ok, clk_i, rst_ni, out_valid_o && ((allocated_block_o != '0) || block_free_o), status_o == bba_pkg::ST_OK)

  // Items are handled one at a time: acceptance closes the input.
  `BBA_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
